FILE: rtl/message_tag_match_queue_macros.svh
// Assertion helpers used by the RTL top level.
`ifndef MESSAGE_TAG_MATCH_QUEUE_MACROS_SVH
`define MESSAGE_TAG_MATCH_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MTMQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define MTMQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mtmq_pkg.sv
package mtmq_pkg;

   localparam logic CMD_ARRIVAL = 1'b0;
   localparam logic CMD_RECEIVE = 1'b1;

   localparam logic [2:0] OUT_DELIVERED = 3'd0;
   localparam logic [2:0] OUT_STORED    = 3'd1;
   localparam logic [2:0] OUT_WAITING   = 3'd2;
   localparam logic [2:0] OUT_OVERFLOW  = 3'd3;
   localparam logic [2:0] OUT_REJECTED  = 3'd4;

   typedef struct packed {
      logic        cmd;
      logic [15:0] comm_id;
      logic [31:0] msg_tag;
      logic [15:0] src_rank;
      logic        any_tag;
      logic        any_source;
      logic [15:0] buf_handle;
   } req_type;

   typedef struct packed {
      logic [2:0]  outcome;
      logic [15:0] out_handle;
      logic [15:0] out_source;
      logic [31:0] out_tag;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] comm;
      logic [31:0] tag;
      logic [15:0] source;
      logic [15:0] handle;
   } entry_type;

   typedef struct packed {
      logic compare;    // latch match flag against the incoming beat
      logic insert_go;  // store new entry in the first free cell
      logic shift;      // take the entry of the upper neighbor
   } cell_ctrl_type;

endpackage

FILE: rtl/mtmq_cell.sv
module mtmq_cell
   import mtmq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  req_type       req,
   input  entry_type     new_entry,
   input  logic          prev_valid,
   input  entry_type     next_entry,
   output entry_type     entry,
   output logic          match
);

   entry_type entry_ff, entry_in;
   logic      match_ff, match_in;
   logic      hit;

   assign hit = entry_ff.valid && (entry_ff.comm == req.comm_id)
             && (req.any_tag    || (entry_ff.tag == req.msg_tag))
             && (req.any_source || (entry_ff.source == req.src_rank));

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift) begin
         entry_in = next_entry;
      end else if (ctrl.insert_go && !entry_ff.valid && prev_valid) begin
         // first free cell: lower neighbor holds an entry, this one does not
         entry_in = new_entry;
      end
      match_in = ctrl.compare ? hit : match_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         match_ff       <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

FILE: rtl/message_tag_match_queue.sv
// Message tag matching queue.
// Request channel: req_data (packet arrival or posted receive) is taken at a
// clock edge where start is high and busy is low. busy stays high while the
// request passes ST_SEARCH and ST_APPLY, so a new beat is taken only after the last one is through.
// Result channel: exactly one result per request, shown on rsp_data for one
// cycle with rsp_strobe high. The strobe rises as the block leaves ST_APPLY;
// the receiver takes the beat while the strobe is high and cannot
// stall; the next request may be taken in the cycle the result shows.
// Stored packets live in a row of QUEUE_DEPTH cells, oldest in cell 0. Each
// cell compares itself to a receive at the accepting edge; the lowest hit is
// picked by one wide subtract over the match vector, and removal shifts the
// cells at or above it down by one neighbor, all in the same cycle. Arrivals are
// delivered to a waiting receive, else fill the first free cell or overflow.
// Synchronous reset empties the queue and drops any waiting receive; the
// first request may be taken in the cycle after reset is released.
module message_tag_match_queue
   import mtmq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

`include "message_tag_match_queue_macros.svh"

   typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_APPLY} state_type;

   localparam logic [QUEUE_DEPTH-1:0] ONE_VEC = QUEUE_DEPTH'(1);

   state_type state_ff;
   req_type   req_ff;
   logic      pend_hit_ff;
   logic      pending_ff;
   logic [15:0] want_comm_ff;
   logic [31:0] want_tag_ff;
   logic [15:0] want_source_ff;
   logic [1:0]  want_wild_ff;
   logic [QUEUE_DEPTH-1:0] hit_ff, shift_mask_ff;
   logic      any_ff;
   logic      rsp_strobe_ff;
   rsp_type   rsp_ff;

   logic      accept;
   logic      pend_hit_in;
   logic      apply_store, apply_remove;
   entry_type new_entry;
   entry_type cells [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] match_vec, valid_vec, dec_vec;
   logic [15:0] sel_handle, sel_source;
   logic [31:0] sel_tag;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign pend_hit_in = pending_ff && (req_data.comm_id == want_comm_ff)
                     && (want_wild_ff[0] || (req_data.msg_tag == want_tag_ff))
                     && (want_wild_ff[1] || (req_data.src_rank == want_source_ff));

   assign apply_store  = (state_ff == ST_APPLY) && (req_ff.cmd == CMD_ARRIVAL)
                      && !pend_hit_ff;
   assign apply_remove = (state_ff == ST_APPLY) && (req_ff.cmd == CMD_RECEIVE)
                      && !pending_ff;

   assign new_entry = '{valid:  1'b1,
                        comm:   req_ff.comm_id,
                        tag:    req_ff.msg_tag,
                        source: req_ff.src_rank,
                        handle: req_ff.buf_handle};

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_ctrl_type ctrl;
      logic          prev_valid;
      entry_type     next_entry;

      assign ctrl = '{compare:   accept,
                      insert_go: apply_store,
                      shift:     apply_remove && shift_mask_ff[i]};

      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_rest
         assign prev_valid = cells[i-1].valid;
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_entry = '0;
      end else begin : g_inner
         assign next_entry = cells[i+1];
      end

      mtmq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .req        (req_data),
         .new_entry  (new_entry),
         .prev_valid (prev_valid),
         .next_entry (next_entry),
         .entry      (cells[i]),
         .match      (match_vec[i])
      );

      assign valid_vec[i] = cells[i].valid;
   end

   // lowest set bit of the match vector, and the cells at or above it
   assign dec_vec = match_vec - ONE_VEC;

   always_comb begin
      sel_handle = '0;
      sel_source = '0;
      sel_tag    = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         sel_handle = sel_handle | ({16{hit_ff[i]}} & cells[i].handle);
         sel_source = sel_source | ({16{hit_ff[i]}} & cells[i].source);
         sel_tag    = sel_tag    | ({32{hit_ff[i]}} & cells[i].tag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pending_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               rsp_strobe_ff <= 1'b0;
               if (accept) begin
                  req_ff      <= req_data;
                  pend_hit_ff <= pend_hit_in;
                  state_ff    <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               rsp_strobe_ff <= 1'b0;
               hit_ff        <= match_vec & ~dec_vec;
               shift_mask_ff <= ~(dec_vec & ~match_vec);
               any_ff        <= |match_vec;
               state_ff      <= ST_APPLY;
            end
            ST_APPLY: begin
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
               if (req_ff.cmd == CMD_ARRIVAL) begin
                  if (pend_hit_ff) begin
                     pending_ff <= 1'b0;
                     rsp_ff     <= '{outcome:    OUT_DELIVERED,
                                     out_handle: req_ff.buf_handle,
                                     out_source: req_ff.src_rank,
                                     out_tag:    req_ff.msg_tag};
                  end else if (!valid_vec[QUEUE_DEPTH-1]) begin
                     rsp_ff <= '{outcome: OUT_STORED, out_handle: '0,
                                 out_source: '0, out_tag: '0};
                  end else begin
                     rsp_ff <= '{outcome: OUT_OVERFLOW, out_handle: '0,
                                 out_source: '0, out_tag: '0};
                  end
               end else if (pending_ff) begin
                  rsp_ff <= '{outcome: OUT_REJECTED, out_handle: '0,
                              out_source: '0, out_tag: '0};
               end else if (any_ff) begin
                  rsp_ff <= '{outcome:    OUT_DELIVERED,
                              out_handle: sel_handle,
                              out_source: sel_source,
                              out_tag:    sel_tag};
               end else begin
                  pending_ff     <= 1'b1;
                  want_comm_ff   <= req_ff.comm_id;
                  want_tag_ff    <= req_ff.msg_tag;
                  want_source_ff <= req_ff.src_rank;
                  want_wild_ff   <= {req_ff.any_source, req_ff.any_tag};
                  rsp_ff         <= '{outcome: OUT_WAITING, out_handle: '0,
                                      out_source: '0, out_tag: '0};
               end
            end
            default: begin
               rsp_strobe_ff <= 1'b0;
               state_ff      <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `MTMQ_ASSERT_NOW(a_hit_onehot, (state_ff == ST_APPLY), $onehot0(hit_ff), "more than one cell picked")
   `MTMQ_ASSERT_NOW(a_valid_prefix, 1'b1, (((valid_vec >> 1) & ~valid_vec) == '0), "queue has a hole")
   `MTMQ_ASSERT_NEXT(a_apply_strobe, (state_ff == ST_APPLY), rsp_strobe, "result beat missing")
   `MTMQ_ASSERT_NEXT(a_accept_busy, accept, (busy && !rsp_strobe), "accept did not start work")

endmodule

FILE: tb/sv/tb_message_tag_match_queue.sv
module tb_message_tag_match_queue;
   import mtmq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH  = 64;
   localparam int RANDOM_ITEMS = 1800;
   localparam int CALM_TAIL    = 200;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 8;

   typedef struct packed {
      req_type req;
      logic    settle;   // hold this beat until all results are back
      logic    gaps;     // idle bursts may follow this beat
   } beat_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   beat_type  pending_beats[$];
   rsp_type   due_results[$];
   entry_type unexpected_pkts[$];
   logic      recv_waiting;
   req_type   want_req;

   int      errors = 0;
   int      launched = 0;
   int      accepts = 0;
   int      gap_left = 0;
   int      stall_cycles = 0;
   beat_type next_beat;
   rsp_type  seen_rsp;
   rsp_type  want_rsp;

   message_tag_match_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic note_failure(input string text);
      $display("[%0t] mismatch: %s", $realtime, text);
      errors++;
   endtask

   function automatic logic pkt_hit(input logic [15:0] comm, input logic [31:0] tag,
                                    input logic [15:0] src, input logic [15:0] wcomm,
                                    input logic [31:0] wtag, input logic [15:0] wsrc,
                                    input logic any_t, input logic any_s);
      return (comm == wcomm) && (any_t || tag == wtag) && (any_s || src == wsrc);
   endfunction

   // Predict one result and advance the queue and the waiting receive.
   function automatic rsp_type match_engine(input req_type r);
      rsp_type   res;
      entry_type e;
      logic      found;
      res   = '0;
      found = 1'b0;
      if (r.cmd == CMD_ARRIVAL) begin
         if (recv_waiting && pkt_hit(r.comm_id, r.msg_tag, r.src_rank, want_req.comm_id,
                                     want_req.msg_tag, want_req.src_rank,
                                     want_req.any_tag, want_req.any_source)) begin
            recv_waiting   = 1'b0;
            res.outcome    = OUT_DELIVERED;
            res.out_handle = r.buf_handle;
            res.out_source = r.src_rank;
            res.out_tag    = r.msg_tag;
         end else if (unexpected_pkts.size() < QUEUE_DEPTH) begin
            e.valid  = 1'b1;
            e.comm   = r.comm_id;
            e.tag    = r.msg_tag;
            e.source = r.src_rank;
            e.handle = r.buf_handle;
            unexpected_pkts.push_back(e);
            res.outcome = OUT_STORED;
         end else begin
            res.outcome = OUT_OVERFLOW;
         end
      end else if (recv_waiting) begin
         res.outcome = OUT_REJECTED;
      end else begin
         // oldest first
         for (int i = 0; i < unexpected_pkts.size() && !found; i++) begin
            e = unexpected_pkts[i];
            if (pkt_hit(e.comm, e.tag, e.source, r.comm_id, r.msg_tag, r.src_rank,
                        r.any_tag, r.any_source)) begin
               found          = 1'b1;
               res.outcome    = OUT_DELIVERED;
               res.out_handle = e.handle;
               res.out_source = e.source;
               res.out_tag    = e.tag;
               unexpected_pkts.delete(i);
            end
         end
         if (!found) begin
            recv_waiting = 1'b1;
            want_req     = r;
            res.outcome  = OUT_WAITING;
         end
      end
      return res;
   endfunction

   function automatic req_type mk_req(input logic cmd, input logic [15:0] comm,
                                      input logic [31:0] tag, input logic [15:0] src,
                                      input logic any_t, input logic any_s,
                                      input logic [15:0] hnd);
      req_type r;
      r.cmd        = cmd;
      r.comm_id    = comm;
      r.msg_tag    = tag;
      r.src_rank   = src;
      r.any_tag    = any_t;
      r.any_source = any_s;
      r.buf_handle = hnd;
      return r;
   endfunction

   // Mostly a small pool so matches happen, sometimes extremes or full random.
   function automatic logic [31:0] pick_key(input logic [31:0] all_ones);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return all_ones;
         8, 9:    return $urandom & all_ones;
         default: return $urandom_range(1, 3);
      endcase
   endfunction

   function automatic req_type rand_req(input logic cmd, input logic noise);
      req_type r;
      if (noise) begin
         r = mk_req(cmd, 16'($urandom), $urandom, 16'($urandom),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'($urandom));
      end else begin
         r = mk_req(cmd, 16'(pick_key(32'h0000_FFFF)), pick_key(32'hFFFF_FFFF),
                    16'(pick_key(32'h0000_FFFF)), $urandom_range(0, 2) == 0,
                    $urandom_range(0, 2) == 0, 16'($urandom));
      end
      return r;
   endfunction

   task automatic queue_beat(input req_type r, input logic settle, input logic gaps);
      beat_type b;
      b.req    = r;
      b.settle = settle;
      b.gaps   = gaps;
      pending_beats.push_back(b);
   endtask

   // Driver: inputs change on the falling edge only.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && accepts != launched) begin
         // beat still offered, hold it
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         start    <= 1'b0;
      end else if (pending_beats.size() == 0) begin
         start <= 1'b0;
      end else if (pending_beats[0].settle && due_results.size() != 0) begin
         start <= 1'b0;
      end else begin
         next_beat = pending_beats.pop_front();
         req_data <= next_beat.req;
         start    <= 1'b1;
         launched <= launched + 1;
         if (next_beat.gaps && $urandom_range(0, 3) == 0)
            gap_left <= $urandom_range(1, 5);
      end
   end

   // Monitor: check results, then predict for the beat taken at this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            seen_rsp = rsp_data;
            if (due_results.size() == 0) begin
               note_failure($sformatf("result with nothing due: %h", seen_rsp));
            end else begin
               want_rsp = due_results.pop_front();
               if (seen_rsp.outcome !== want_rsp.outcome)
                  note_failure($sformatf("outcome %0d, want %0d",
                                         seen_rsp.outcome, want_rsp.outcome));
               if (seen_rsp.out_handle !== want_rsp.out_handle)
                  note_failure($sformatf("out_handle %h, want %h",
                                         seen_rsp.out_handle, want_rsp.out_handle));
               if (seen_rsp.out_source !== want_rsp.out_source)
                  note_failure($sformatf("out_source %h, want %h",
                                         seen_rsp.out_source, want_rsp.out_source));
               if (seen_rsp.out_tag !== want_rsp.out_tag)
                  note_failure($sformatf("out_tag %h, want %h",
                                         seen_rsp.out_tag, want_rsp.out_tag));
            end
         end
         if (start && !busy) begin
            due_results.push_back(match_engine(req_data));
            accepts <= accepts + 1;
         end
      end
   end

   // Watchdog on cycles without any beat moving.
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe)
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      int made;
      int burst;
      int mode;
      req_type rnd_req;
      recv_waiting = 1'b0;
      want_req     = '0;

      // directed: empty-queue receive, rejection, ignored flags, oldest-first,
      // wildcards on tag and source, extremes of every field
      queue_beat(mk_req(CMD_RECEIVE, 16'h0, 32'h0, 16'h0, 1'b0, 1'b0, 16'h0), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_RECEIVE, 16'h0, 32'h0, 16'h0, 1'b1, 1'b1, 16'hFFFF), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_ARRIVAL, 16'h1, 32'h0, 16'h0, 1'b0, 1'b0, 16'h0011), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_ARRIVAL, 16'h0, 32'h0, 16'h0, 1'b1, 1'b1, 16'hFFFF), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_ARRIVAL, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0,
                        16'h1234), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_ARRIVAL, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0,
                        16'h0000), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_RECEIVE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0,
                        16'hABCD), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_RECEIVE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0,
                        16'hFFFF), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_ARRIVAL, 16'h2, 32'h5, 16'h7, 1'b0, 1'b0, 16'h0021), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_ARRIVAL, 16'h2, 32'h6, 16'h8, 1'b0, 1'b0, 16'h0022), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_RECEIVE, 16'h2, 32'h0, 16'h8, 1'b1, 1'b0, 16'h0), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_RECEIVE, 16'h2, 32'h5, 16'h0, 1'b0, 1'b1, 16'h0), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_RECEIVE, 16'h2, 32'h0, 16'h0, 1'b1, 1'b1, 16'h0), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_ARRIVAL, 16'h3, 32'h1, 16'h1, 1'b0, 1'b0, 16'h0031), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_ARRIVAL, 16'h2, 32'h8000_0000, 16'h8000, 1'b0, 1'b0,
                        16'h8000), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_RECEIVE, 16'h1, 32'h0, 16'h0, 1'b0, 1'b0, 16'h0), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_RECEIVE, 16'h5, 32'h9, 16'h9, 1'b0, 1'b0, 16'h0), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_ARRIVAL, 16'h5, 32'h9, 16'h8, 1'b0, 1'b0, 16'h0051), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_ARRIVAL, 16'h5, 32'h8, 16'h9, 1'b0, 1'b0, 16'h0052), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_ARRIVAL, 16'h4, 32'h9, 16'h9, 1'b0, 1'b0, 16'h0053), 1'b0, 1'b0);
      queue_beat(mk_req(CMD_ARRIVAL, 16'h5, 32'h9, 16'h9, 1'b1, 1'b1, 16'h0054), 1'b0, 1'b0);

      // random: overflow fill first, then mixed, drain, fill and noise bursts
      made = 0;
      mode = 0;
      while (made < RANDOM_ITEMS) begin
         case (mode)
            0:       burst = $urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 8);
            7:       burst = $urandom_range(10, 30);
            default: burst = $urandom_range(8, 40);
         endcase
         for (int k = 0; k < burst && made < RANDOM_ITEMS; k++) begin
            case (mode)
               0:       rnd_req = rand_req(CMD_ARRIVAL, 1'b0);
               7:       rnd_req = rand_req($urandom_range(0, 3) != 0, 1'b0);
               8:       rnd_req = rand_req(1'($urandom_range(0, 1)), 1'b1);
               default: rnd_req = rand_req(1'($urandom_range(0, 1)), 1'b0);
            endcase
            queue_beat(rnd_req, made == RANDOM_ITEMS / 2,
                       made < RANDOM_ITEMS - CALM_TAIL);
            made++;
         end
         mode = $urandom_range(0, 9);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      do @(posedge clock);
      while (pending_beats.size() != 0 || start || due_results.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (due_results.size() != 0)
         note_failure($sformatf("%0d results never arrived", due_results.size()));
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/mtmq_pkg.sv
rtl/mtmq_cell.sv
rtl/message_tag_match_queue.sv
tb/sv/tb_message_tag_match_queue.sv
